### src/ptql_pkg.sv
// ----------------------------------------------------------------------------
// ptql_pkg
// shared types and constants for the text quad layout block
// ----------------------------------------------------------------------------
package ptql_pkg;

    localparam logic [2:0] MODE_METRIC  = 3'd0;
    localparam logic [2:0] MODE_COLOR   = 3'd1;
    localparam logic [2:0] MODE_BEGIN   = 3'd2;
    localparam logic [2:0] MODE_MEASURE = 3'd3;
    localparam logic [2:0] MODE_DRAW    = 3'd4;

    localparam logic [2:0] CFG_FONT_SIZE      = 3'd0;
    localparam logic [2:0] CFG_CHAR_SPACING   = 3'd1;
    localparam logic [2:0] CFG_CHAR_PADDING   = 3'd2;
    localparam logic [2:0] CFG_MONOSPACED     = 3'd3;
    localparam logic [2:0] CFG_CASE_MODE      = 3'd4;
    localparam logic [2:0] CFG_PATTERN_LENGTH = 3'd5;

    localparam logic [1:0] CASE_NONE  = 2'd0;
    localparam logic [1:0] CASE_LOWER = 2'd1;
    localparam logic [1:0] CASE_UPPER = 2'd2;

    localparam logic [11:0] FONT_SIZE_RESET    = 12'd640;
    localparam logic [15:0] CHAR_SPACING_RESET = 16'd39322;
    localparam logic [15:0] CHAR_PADDING_RESET = 16'd3277;

    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [31:0] WHITE      = 32'hFFFF_FFFF;

    localparam logic signed [19:0] POS_MAX = 20'sh7FFFF;
    localparam logic signed [19:0] POS_MIN = 20'sh80000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [1:0] {
        OP_COLOR,
        OP_BEGIN,
        OP_MEASURE,
        OP_DRAW
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_V1,
        BK_V2,
        BK_V3
    } back_state_t;

    typedef struct packed {
        logic [11:0] font_size;
        logic [15:0] char_spacing;
        logic [15:0] char_padding;
        logic        monospaced;
        logic [1:0]  case_mode;
        logic [4:0]  pattern_length;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [7:0]         ch;
        logic [12:0]        lp;
        logic signed [14:0] delta0;
        logic signed [14:0] delta1;
        logic [12:0]        adv;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic               center;
        logic [7:0]         cidx;
        logic [31:0]        cword;
    } qent_t;

endpackage

### src/ptql_front.sv
// ----------------------------------------------------------------------------
// ptql_front
// input stage: case folding, glyph metric store, margin products
// ----------------------------------------------------------------------------
module ptql_front #(
    parameter int GLYPH_COUNT = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptql_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            mode,
    input  logic [7:0]            index,
    input  logic [15:0]           left_margin,
    input  logic [15:0]           right_margin,
    input  logic [31:0]           color_word,
    input  logic signed [19:0]    pos_x,
    input  logic signed [19:0]    pos_y,
    input  logic                  center,
    input  logic [7:0]            character,
    output logic                  push_valid,
    output ptql_pkg::qent_t       push_ent,
    input  logic                  q_full
);

    localparam int GW = $clog2(GLYPH_COUNT);

    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'd32;

    function automatic logic [12:0] fsmul(input logic [11:0] fs, input logic [16:0] frac);
        logic [29:0] p;
        p = 30'(fs) * 30'(frac) + 30'd32768;
        return p[28:16];
    endfunction

    logic [31:0] metric_mem [GLYPH_COUNT];
    logic [31:0] metric_q;

    logic            stall;
    logic            accept;
    logic            fwd;
    ptql_pkg::op_t   op;
    logic [7:0]      fold_ch;

    logic            a_valid_reg;
    ptql_pkg::qent_t a_ent_reg;
    logic            a_inrange_reg;

    logic            b_valid_reg;
    ptql_pkg::qent_t b_ent_reg;
    logic [12:0]     b_rp_reg;

    logic            c_valid_reg;
    ptql_pkg::qent_t c_ent_reg;

    logic [12:0]     pad_p_reg;
    logic [12:0]     spc_p_reg;

    logic signed [14:0] rml;
    logic signed [14:0] d0;
    logic signed [14:0] d1;
    logic [12:0]        adv;
    logic [15:0]        lsel;
    logic [15:0]        rsel;

    assign stall    = c_valid_reg && q_full;
    assign in_ready = !stall;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        fold_ch = character;
        if (cfg.case_mode == ptql_pkg::CASE_LOWER && character >= UPPER_A &&
            character <= UPPER_Z)
        begin
            fold_ch = character + CASE_GAP;
        end
        else if (cfg.case_mode == ptql_pkg::CASE_UPPER && character >= LOWER_A &&
                 character <= LOWER_Z)
        begin
            fold_ch = character - CASE_GAP;
        end
    end

    always_comb
    begin
        fwd = 1'b1;
        op  = ptql_pkg::OP_DRAW;
        unique case (mode)
            ptql_pkg::MODE_COLOR:   op = ptql_pkg::OP_COLOR;
            ptql_pkg::MODE_BEGIN:   op = ptql_pkg::OP_BEGIN;
            ptql_pkg::MODE_MEASURE: op = ptql_pkg::OP_MEASURE;
            ptql_pkg::MODE_DRAW:    op = ptql_pkg::OP_DRAW;
            default:                fwd = 1'b0;
        endcase
    end

    // glyph metric store, left margin in the upper half
    always_ff @(posedge clk)
    begin
        if (accept && mode == ptql_pkg::MODE_METRIC && {1'b0, index} < 9'(GLYPH_COUNT))
        begin
            metric_mem[index[GW-1:0]] <= {left_margin, right_margin};
        end
        if (!stall)
        begin
            metric_q <= metric_mem[fold_ch[GW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        pad_p_reg <= fsmul(cfg.font_size, {1'b0, cfg.char_padding});
        spc_p_reg <= fsmul(cfg.font_size, {1'b0, cfg.char_spacing});
    end

    always_comb
    begin
        lsel = a_inrange_reg ? metric_q[31:16] : 16'd0;
        rsel = a_inrange_reg ? metric_q[15:0] : 16'd0;
    end

    always_comb
    begin
        rml = $signed({2'b00, b_rp_reg}) - $signed({2'b00, b_ent_reg.lp});
        if (cfg.monospaced)
        begin
            d0  = (b_ent_reg.ch == ptql_pkg::CHAR_SPACE) ? $signed({2'b00, spc_p_reg})
                                                         : $signed({3'b000, cfg.font_size});
            d1  = d0;
            adv = spc_p_reg;
        end
        else
        begin
            d0  = rml;
            d1  = rml + $signed({2'b00, pad_p_reg});
            adv = b_rp_reg + pad_p_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            a_valid_reg <= accept && fwd;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            a_ent_reg        <= '0;
            a_ent_reg.op     <= op;
            a_ent_reg.ch     <= fold_ch;
            a_ent_reg.pos_x  <= pos_x;
            a_ent_reg.pos_y  <= pos_y;
            a_ent_reg.center <= center;
            a_ent_reg.cidx   <= index;
            a_ent_reg.cword  <= color_word;
            a_inrange_reg    <= {1'b0, fold_ch} < 9'(GLYPH_COUNT);

            b_ent_reg        <= a_ent_reg;
            b_ent_reg.lp     <= fsmul(cfg.font_size, {1'b0, lsel});
            b_rp_reg         <= fsmul(cfg.font_size, 17'h10000 - {1'b0, rsel});

            c_ent_reg        <= b_ent_reg;
            c_ent_reg.delta0 <= d0;
            c_ent_reg.delta1 <= d1;
            c_ent_reg.adv    <= adv;
        end
    end

    assign push_valid = c_valid_reg;
    assign push_ent   = c_ent_reg;

endmodule

### src/ptql_queue.sv
// ----------------------------------------------------------------------------
// ptql_queue
// short queue between the input stage and the vertex sequencer
// ----------------------------------------------------------------------------
module ptql_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  ptql_pkg::qent_t push_ent,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output ptql_pkg::qent_t head
);

    ptql_pkg::qent_t entries [ptql_pkg::QUEUE_DEPTH];

    logic [ptql_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [ptql_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [ptql_pkg::QPTR_W:0]   count_reg;
    logic                        push;
    logic                        do_pop;

    assign full   = count_reg == (ptql_pkg::QPTR_W + 1)'(ptql_pkg::QUEUE_DEPTH);
    assign empty  = count_reg == '0;
    assign push   = push_valid && !full;
    assign do_pop = pop && !empty;
    assign head   = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### src/ptql_back.sv
// ----------------------------------------------------------------------------
// ptql_back
// pen and width state, colour pattern store and vertex sequencer
// ----------------------------------------------------------------------------
module ptql_back #(
    parameter int PATTERN_ENTRIES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptql_pkg::cfg_t        cfg,
    input  logic                  q_empty,
    input  ptql_pkg::qent_t       q_head,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [19:0]    vert_x,
    output logic signed [19:0]    vert_y,
    output logic [16:0]           tex_s,
    output logic [16:0]           tex_t,
    output logic [31:0]           vertex_color,
    output logic signed [19:0]    text_width,
    output logic                  last
);

    localparam int CW  = (PATTERN_ENTRIES > 1) ? $clog2(PATTERN_ENTRIES) : 1;
    localparam int LW0 = $clog2(PATTERN_ENTRIES + 1);
    localparam int LW  = (LW0 > 5) ? LW0 : 5;

    function automatic logic signed [21:0] ext22(input logic signed [19:0] v);
        return {{2{v[19]}}, v};
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
        if (v > ext22(ptql_pkg::POS_MAX))
        begin
            return ptql_pkg::POS_MAX;
        end
        else if (v < ext22(ptql_pkg::POS_MIN))
        begin
            return ptql_pkg::POS_MIN;
        end
        return v[19:0];
    endfunction

    ptql_pkg::back_state_t state_reg, state_next;

    logic signed [19:0] pen_x_reg, pen_x_next;
    logic signed [19:0] pen_y_reg, pen_y_next;
    logic signed [19:0] width_reg, width_next;
    logic               has_chars_reg, has_chars_next;
    logic [CW-1:0]      color_pos_reg, color_pos_next;
    logic signed [19:0] x1_reg, x1_next;
    logic signed [19:0] y1_reg, y1_next;
    logic [12:0]        adv_reg, adv_next;
    logic [3:0]         col_reg, col_next;
    logic [3:0]         row_reg, row_next;

    logic               out_valid_reg, out_valid_next;
    logic               load_out;
    logic signed [19:0] ox, oy, ow;
    logic [16:0]        os, ot;
    logic [31:0]        oc;
    logic               ol;

    logic [31:0]        ctab [PATTERN_ENTRIES];
    logic [31:0]        col_q;
    logic               cwe;
    logic [CW-1:0]      waddr;
    logic [CW-1:0]      raddr;

    logic               can_emit;
    logic               emit_vtx;
    logic               begin_clear;
    logic [LW-1:0]      len;
    logic [CW-1:0]      pos_now;
    logic [LW-1:0]      pos_inc;
    logic [31:0]        vcolor;
    logic signed [19:0] x0, x1, y1, wnew;
    logic signed [14:0] dsel;
    logic [16:0]        s_left, s_right, t_top, t_bot;

    assign can_emit = !out_valid_reg || out_ready;
    assign waddr    = q_head.cidx[CW-1:0];

    always_comb
    begin
        len = (LW'(cfg.pattern_length) > LW'(PATTERN_ENTRIES)) ? LW'(PATTERN_ENTRIES)
                                                               : LW'(cfg.pattern_length);
        pos_now = ({{(LW-CW){1'b0}}, color_pos_reg} >= len) ? '0 : color_pos_reg;
        pos_inc = {{(LW-CW){1'b0}}, pos_now} + 1'b1;
        vcolor  = (len == '0) ? ptql_pkg::WHITE : col_q;
    end

    always_comb
    begin
        s_left  = {1'b0, col_reg, 12'd0};
        s_right = {{1'b0, col_reg} + 5'd1, 12'd0};
        t_top   = {5'd15 - {1'b0, row_reg}, 12'd0};
        t_bot   = {5'd16 - {1'b0, row_reg}, 12'd0};
    end

    always_comb
    begin
        state_next     = state_reg;
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        width_next     = width_reg;
        has_chars_next = has_chars_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        adv_next       = adv_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        q_pop          = 1'b0;
        cwe            = 1'b0;
        emit_vtx       = 1'b0;
        begin_clear    = 1'b0;
        load_out       = 1'b0;
        ox             = '0;
        oy             = '0;
        os             = '0;
        ot             = '0;
        oc             = '0;
        ow             = '0;
        ol             = 1'b0;

        dsel = has_chars_reg ? q_head.delta1 : q_head.delta0;
        wnew = sat20(ext22(width_reg) + {{7{dsel[14]}}, dsel});
        x0   = cfg.monospaced ? pen_x_reg
                              : sat20(ext22(pen_x_reg) - {9'd0, q_head.lp});
        y1   = sat20(ext22(pen_y_reg) + {10'd0, cfg.font_size});
        x1   = sat20(ext22(pen_x_reg) + {10'd0, cfg.font_size});

        unique case (state_reg)
            ptql_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_head.op)
                        ptql_pkg::OP_COLOR:
                        begin
                            q_pop = 1'b1;
                            cwe   = q_head.cidx < 8'(PATTERN_ENTRIES);
                        end
                        ptql_pkg::OP_BEGIN:
                        begin
                            q_pop = 1'b1;
                            begin_clear = 1'b1;
                            pen_x_next = sat20(ext22(q_head.pos_x) -
                                (q_head.center ? ext22(width_reg >>> 1) : 22'sd0));
                            pen_y_next = sat20(ext22(q_head.pos_y) -
                                (q_head.center ? {11'd0, cfg.font_size[11:1]} : 22'sd0));
                            width_next     = '0;
                            has_chars_next = 1'b0;
                        end
                        ptql_pkg::OP_MEASURE:
                        begin
                            if (can_emit)
                            begin
                                q_pop          = 1'b1;
                                width_next     = wnew;
                                has_chars_next = 1'b1;
                                load_out       = 1'b1;
                                ow             = wnew;
                                ol             = 1'b1;
                            end
                        end
                        ptql_pkg::OP_DRAW:
                        begin
                            if (can_emit)
                            begin
                                q_pop      = 1'b1;
                                emit_vtx   = 1'b1;
                                load_out   = 1'b1;
                                pen_x_next = x0;
                                y1_next    = y1;
                                adv_next   = q_head.adv;
                                col_next   = q_head.ch[3:0];
                                row_next   = q_head.ch[7:4];
                                ox         = x0;
                                oy         = y1;
                                os         = {1'b0, q_head.ch[3:0], 12'd0};
                                ot         = {5'd15 - {1'b0, q_head.ch[7:4]}, 12'd0};
                                oc         = vcolor;
                                state_next = ptql_pkg::BK_V1;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ptql_pkg::BK_V1:
            begin
                if (can_emit)
                begin
                    emit_vtx   = 1'b1;
                    load_out   = 1'b1;
                    x1_next    = x1;
                    ox         = x1;
                    oy         = y1_reg;
                    os         = s_right;
                    ot         = t_top;
                    oc         = vcolor;
                    state_next = ptql_pkg::BK_V2;
                end
            end
            ptql_pkg::BK_V2:
            begin
                if (can_emit)
                begin
                    emit_vtx   = 1'b1;
                    load_out   = 1'b1;
                    ox         = x1_reg;
                    oy         = pen_y_reg;
                    os         = s_right;
                    ot         = t_bot;
                    oc         = vcolor;
                    state_next = ptql_pkg::BK_V3;
                end
            end
            ptql_pkg::BK_V3:
            begin
                if (can_emit)
                begin
                    emit_vtx   = 1'b1;
                    load_out   = 1'b1;
                    ox         = pen_x_reg;
                    oy         = pen_y_reg;
                    os         = s_left;
                    ot         = t_bot;
                    oc         = vcolor;
                    ol         = 1'b1;
                    pen_x_next = sat20(ext22(pen_x_reg) + {9'd0, adv_reg});
                    state_next = ptql_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ptql_pkg::BK_IDLE;
            end
        endcase

        out_valid_next = load_out ? 1'b1 : (out_valid_reg && !out_ready);
    end

    // colour position and prefetch address for the next cycle
    always_comb
    begin
        if (begin_clear)
        begin
            color_pos_next = '0;
        end
        else if (emit_vtx && len != '0)
        begin
            color_pos_next = (pos_inc >= len) ? '0 : pos_inc[CW-1:0];
        end
        else
        begin
            color_pos_next = color_pos_reg;
        end
        raddr = ({{(LW-CW){1'b0}}, color_pos_next} >= len) ? '0 : color_pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (cwe)
        begin
            ctab[waddr] <= q_head.cword;
        end
        col_q <= (cwe && waddr == raddr) ? q_head.cword : ctab[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptql_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            width_reg     <= '0;
            has_chars_reg <= 1'b0;
            color_pos_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            width_reg     <= width_next;
            has_chars_reg <= has_chars_next;
            color_pos_reg <= color_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg  <= x1_next;
        y1_reg  <= y1_next;
        adv_reg <= adv_next;
        col_reg <= col_next;
        row_reg <= row_next;
        if (load_out)
        begin
            vert_x       <= ox;
            vert_y       <= oy;
            tex_s        <= os;
            tex_t        <= ot;
            vertex_color <= oc;
            text_width   <= ow;
            last         <= ol;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### src/proportional_text_quad_layout.sv
// ----------------------------------------------------------------------------
// proportional_text_quad_layout
// fixed-point text layout for a 16x16 glyph atlas, four vertices per glyph
// ----------------------------------------------------------------------------
// A drawn character gives four vertex beats: the vertex sequencer steps
// through its idle, V1, V2 and V3 states and fills the single output
// register once per cycle while the output side keeps up, taking the next
// character only after the last vertex of the one before. Measure, begin
// and colour load items are handled in the idle state; metric load items
// stay in the input stage. An input beat is accepted every cycle while the
// four-entry queue has room; an accepted item passes three input stages,
// the queue and the output register before its result appears.
// Configuration writes must only be issued while no item is in flight.
module proportional_text_quad_layout #(
    parameter int GLYPH_COUNT     = 256,
    parameter int PATTERN_ENTRIES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            mode,
    input  logic [7:0]            index,
    input  logic [15:0]           left_margin,
    input  logic [15:0]           right_margin,
    input  logic [31:0]           color_word,
    input  logic signed [19:0]    pos_x,
    input  logic signed [19:0]    pos_y,
    input  logic                  center,
    input  logic [7:0]            character,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [19:0]    vert_x,
    output logic signed [19:0]    vert_y,
    output logic [16:0]           tex_s,
    output logic [16:0]           tex_t,
    output logic [31:0]           vertex_color,
    output logic signed [19:0]    text_width,
    output logic                  last
);

    ptql_pkg::cfg_t  cfg_reg;
    logic            push_valid;
    ptql_pkg::qent_t push_ent;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    ptql_pkg::qent_t q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.font_size      <= ptql_pkg::FONT_SIZE_RESET;
            cfg_reg.char_spacing   <= ptql_pkg::CHAR_SPACING_RESET;
            cfg_reg.char_padding   <= ptql_pkg::CHAR_PADDING_RESET;
            cfg_reg.monospaced     <= 1'b0;
            cfg_reg.case_mode      <= ptql_pkg::CASE_NONE;
            cfg_reg.pattern_length <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ptql_pkg::CFG_FONT_SIZE:      cfg_reg.font_size      <= cfg_data[11:0];
                ptql_pkg::CFG_CHAR_SPACING:   cfg_reg.char_spacing   <= cfg_data;
                ptql_pkg::CFG_CHAR_PADDING:   cfg_reg.char_padding   <= cfg_data;
                ptql_pkg::CFG_MONOSPACED:     cfg_reg.monospaced     <= cfg_data[0];
                ptql_pkg::CFG_CASE_MODE:      cfg_reg.case_mode      <= cfg_data[1:0];
                ptql_pkg::CFG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    ptql_front #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .index        (index),
        .left_margin  (left_margin),
        .right_margin (right_margin),
        .color_word   (color_word),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .center       (center),
        .character    (character),
        .push_valid   (push_valid),
        .push_ent     (push_ent),
        .q_full       (q_full)
    );

    ptql_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ent   (push_ent),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    ptql_back #(
        .PATTERN_ENTRIES (PATTERN_ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vert_x       (vert_x),
        .vert_y       (vert_y),
        .tex_s        (tex_s),
        .tex_t        (tex_t),
        .vertex_color (vertex_color),
        .text_width   (text_width),
        .last         (last)
    );

endmodule

### src/ptql_checker.sv
// ----------------------------------------------------------------------------
// ptql_checker
// port-level checks on the result channel of the text layout block
// ----------------------------------------------------------------------------
module ptql_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [19:0]  vert_x,
    input logic signed [19:0]  vert_y,
    input logic [16:0]         tex_s,
    input logic [16:0]         tex_t,
    input logic [31:0]         vertex_color,
    input logic signed [19:0]  text_width,
    input logic                last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vert_x) && $stable(vert_y) &&
            $stable(tex_s) && $stable(tex_t) && $stable(vertex_color) &&
            $stable(text_width) && $stable(last))
        else $error("result payload changed while stalled");

    // vertex beats before the last of a glyph carry cell-aligned atlas coordinates
    a_vertex_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> text_width == 20'sd0 && tex_s[11:0] == 12'd0 &&
            tex_t[11:0] == 12'd0 && tex_s <= 17'h10000 && tex_t <= 17'h10000)
        else $error("malformed vertex beat");

    // a nonzero width only comes from a measure beat
    a_measure_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_width != 20'sd0 |-> last && vert_x == 20'sd0 &&
            vert_y == 20'sd0 && tex_s == 17'd0 && tex_t == 17'd0 &&
            vertex_color == 32'd0)
        else $error("malformed measure beat");

endmodule

bind proportional_text_quad_layout ptql_checker u_ptql_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vert_x       (vert_x),
    .vert_y       (vert_y),
    .tex_s        (tex_s),
    .tex_t        (tex_t),
    .vertex_color (vertex_color),
    .text_width   (text_width),
    .last         (last)
);

### verif/proportional_text_quad_layout_test.sv
// ----------------------------------------------------------------------------
// proportional_text_quad_layout_test
// self-checking bench for the text quad layout block: a cycle-free model of
// the pen, width, colour and metric state predicts every vertex and width
// beat, while random gaps and output stalls exercise both handshakes
// ----------------------------------------------------------------------------
module proportional_text_quad_layout_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ptql_pkg::*;

    localparam int GLYPH_COUNT     = 256;
    localparam int PATTERN_ENTRIES = 16;
    localparam int CELL_STEP       = 4096;
    localparam int TEX_ONE         = 65536;
    localparam int SETTLE_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
    localparam logic [2:0] CFG_SPARE_FIRST  = 3'd6;
    localparam logic [2:0] CFG_SPARE_LAST   = 3'd7;

    typedef struct {
        logic [2:0]         mode;
        logic [7:0]         index;
        logic [15:0]        left;
        logic [15:0]        right;
        logic [31:0]        colour;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic               centre;
        logic [7:0]         glyph;
    } layout_item_t;

    typedef struct {
        logic signed [19:0] vx;
        logic signed [19:0] vy;
        logic [16:0]        s;
        logic [16:0]        t;
        logic [31:0]        tint;
        logic signed [19:0] width;
        logic               last_beat;
    } quad_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [2:0] mode;
    logic [7:0] index;
    logic [15:0] left_margin;
    logic [15:0] right_margin;
    logic [31:0] color_word;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic center;
    logic [7:0] character;
    logic out_valid;
    logic out_ready;
    logic signed [19:0] vert_x;
    logic signed [19:0] vert_y;
    logic [16:0] tex_s;
    logic [16:0] tex_t;
    logic [31:0] vertex_color;
    logic signed [19:0] text_width;
    logic last;

    // layout state as the block should hold it
    cfg_t               regs;
    logic [15:0]        left_frac [GLYPH_COUNT];
    logic [15:0]        right_frac [GLYPH_COUNT];
    bit                 metric_known [GLYPH_COUNT];
    logic [31:0]        palette [PATTERN_ENTRIES];
    logic signed [19:0] pen_x;
    logic signed [19:0] pen_y;
    int                 tint_slot;
    logic signed [19:0] measured_width;
    int                 glyphs_measured;

    quad_beat_t quad_beats_due [$];

    bit no_gaps;
    int mismatches;
    int items_taken;
    int vertex_beats;
    int width_beats;
    int cfg_writes;
    int quiet_cycles;

    proportional_text_quad_layout i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .index        (index),
        .left_margin  (left_margin),
        .right_margin (right_margin),
        .color_word   (color_word),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .center       (center),
        .character    (character),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vert_x       (vert_x),
        .vert_y       (vert_y),
        .tex_s        (tex_s),
        .tex_t        (tex_t),
        .vertex_color (vertex_color),
        .text_width   (text_width),
        .last         (last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // layout model
    // ------------------------------------------------------------------------
    function automatic logic signed [19:0] clamp_pos(input longint v);
        if (v > POS_MAX)
            return POS_MAX;
        if (v < POS_MIN)
            return POS_MIN;
        return v[19:0];
    endfunction

    function automatic longint scale_fs(input longint frac);
        return (longint'(regs.font_size) * frac + 32768) >>> 16;
    endfunction

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        if (regs.case_mode == CASE_LOWER && c >= "A" && c <= "Z")
            return c + 8'd32;
        if (regs.case_mode == CASE_UPPER && c >= "a" && c <= "z")
            return c - 8'd32;
        return c;
    endfunction

    function automatic longint left_of(input logic [7:0] c);
        return (c < GLYPH_COUNT) ? longint'(left_frac[c]) : 0;
    endfunction

    function automatic longint right_of(input logic [7:0] c);
        return (c < GLYPH_COUNT) ? longint'(right_frac[c]) : 0;
    endfunction

    function automatic logic [31:0] next_tint();
        int span;
        logic [31:0] c;
        span = (regs.pattern_length > PATTERN_ENTRIES) ? PATTERN_ENTRIES
                                                       : regs.pattern_length;
        if (span == 0)
            return WHITE;
        if (tint_slot >= span)
            tint_slot = 0;
        c = palette[tint_slot];
        tint_slot++;
        if (tint_slot >= span)
            tint_slot = 0;
        return c;
    endfunction

    function automatic void reset_layout_state();
        regs.font_size      = FONT_SIZE_RESET;
        regs.char_spacing   = CHAR_SPACING_RESET;
        regs.char_padding   = CHAR_PADDING_RESET;
        regs.monospaced     = 1'b0;
        regs.case_mode      = CASE_NONE;
        regs.pattern_length = '0;
        foreach (metric_known[i])
            metric_known[i] = 1'b0;
        pen_x           = '0;
        pen_y           = '0;
        tint_slot       = 0;
        measured_width  = '0;
        glyphs_measured = 0;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            CFG_FONT_SIZE:      regs.font_size = data[11:0];
            CFG_CHAR_SPACING:   regs.char_spacing = data;
            CFG_CHAR_PADDING:   regs.char_padding = data;
            CFG_MONOSPACED:     regs.monospaced = data[0];
            CFG_CASE_MODE:      regs.case_mode = data[1:0];
            CFG_PATTERN_LENGTH: regs.pattern_length = data[4:0];
            default: ;
        endcase
    endfunction

    function automatic void advance_layout(input layout_item_t it);
        logic [7:0] glyph;
        longint acc;
        longint x;
        longint y;
        logic signed [19:0] x0;
        logic signed [19:0] x1;
        logic signed [19:0] y0;
        logic signed [19:0] y1;
        int s_base;
        int t_base;
        bit right_edge;
        bit top_edge;
        quad_beat_t beat;
        glyph = fold_char(it.glyph);
        case (it.mode)
            MODE_METRIC:
            begin
                if (it.index < GLYPH_COUNT)
                begin
                    left_frac[it.index]    = it.left;
                    right_frac[it.index]   = it.right;
                    metric_known[it.index] = 1'b1;
                end
            end
            MODE_COLOR:
            begin
                if (it.index < PATTERN_ENTRIES)
                    palette[it.index] = it.colour;
            end
            MODE_BEGIN:
            begin
                x = longint'(it.x);
                y = longint'(it.y);
                if (it.centre)
                begin
                    x = x - (longint'(measured_width) >>> 1);
                    y = y - longint'(regs.font_size >> 1);
                end
                pen_x           = clamp_pos(x);
                pen_y           = clamp_pos(y);
                measured_width  = '0;
                glyphs_measured = 0;
                tint_slot       = 0;
            end
            MODE_MEASURE:
            begin
                acc = longint'(measured_width);
                if (regs.monospaced)
                    acc += (glyph == CHAR_SPACE) ? scale_fs(regs.char_spacing)
                                                 : longint'(regs.font_size);
                else
                begin
                    acc += scale_fs(TEX_ONE - right_of(glyph)) - scale_fs(left_of(glyph));
                    if (glyphs_measured != 0)
                        acc += scale_fs(regs.char_padding);
                end
                measured_width = clamp_pos(acc);
                if (glyphs_measured < 65535)
                    glyphs_measured++;
                beat.vx        = '0;
                beat.vy        = '0;
                beat.s         = '0;
                beat.t         = '0;
                beat.tint      = '0;
                beat.width     = measured_width;
                beat.last_beat = 1'b1;
                quad_beats_due.push_back(beat);
            end
            MODE_DRAW:
            begin
                s_base = glyph[3:0] * CELL_STEP;
                t_base = TEX_ONE - glyph[7:4] * CELL_STEP;
                if (!regs.monospaced)
                    pen_x = clamp_pos(longint'(pen_x) - scale_fs(left_of(glyph)));
                x0 = pen_x;
                x1 = clamp_pos(longint'(pen_x) + longint'(regs.font_size));
                y0 = pen_y;
                y1 = clamp_pos(longint'(pen_y) + longint'(regs.font_size));
                // corners: top left, top right, bottom right, bottom left
                for (int k = 0; k < 4; k++)
                begin
                    right_edge     = (k == 1 || k == 2);
                    top_edge       = (k < 2);
                    beat.vx        = right_edge ? x1 : x0;
                    beat.vy        = top_edge ? y1 : y0;
                    beat.s         = right_edge ? s_base + CELL_STEP : s_base;
                    beat.t         = top_edge ? t_base - CELL_STEP : t_base;
                    beat.tint      = next_tint();
                    beat.width     = '0;
                    beat.last_beat = (k == 3);
                    quad_beats_due.push_back(beat);
                end
                if (regs.monospaced)
                    pen_x = clamp_pos(longint'(pen_x) + scale_fs(regs.char_spacing));
                else
                    pen_x = clamp_pos(longint'(pen_x) + scale_fs(TEX_ONE - right_of(glyph))
                                      + scale_fs(regs.char_padding));
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic signed [19:0] rand_pos();
        logic signed [19:0] v;
        if ($urandom_range(0, 3) != 0)
        begin
            v = $urandom_range(0, 16383);
            v = v - 20'sd8192;
        end
        else
            v = $urandom;
        return v;
    endfunction

    function automatic logic [15:0] rand_frac();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 16'h0000;
        if (roll == 1)
            return 16'hFFFF;
        if (roll < 6)
            return $urandom_range(0, 16383);
        return $urandom;
    endfunction

    // only characters whose folded code has margins loaded, unless monospaced
    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 3)
            c = "A" + $urandom_range(0, 25);
        else if (roll < 6)
            c = "a" + $urandom_range(0, 25);
        else if (roll == 6)
            c = CHAR_SPACE;
        else
            c = $urandom;
        for (int k = 0; k < GLYPH_COUNT; k++)
        begin
            if (regs.monospaced || metric_known[fold_char(c)])
                break;
            c = c + 8'd1;
        end
        return c;
    endfunction

    function automatic layout_item_t make_item(input logic [2:0] m);
        layout_item_t it;
        it.mode   = m;
        it.index  = $urandom;
        it.left   = $urandom;
        it.right  = $urandom;
        it.colour = $urandom;
        it.x      = rand_pos();
        it.y      = rand_pos();
        it.centre = $urandom_range(0, 1);
        it.glyph  = $urandom;
        return it;
    endfunction

    task automatic send_item(input layout_item_t it);
        int unsigned gap;
        gap = idle_len();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= it.mode;
        index        <= it.index;
        left_margin  <= it.left;
        right_margin <= it.right;
        color_word   <= it.colour;
        pos_x        <= it.x;
        pos_y        <= it.y;
        center       <= it.centre;
        character    <= it.glyph;
        do
            @(posedge clk);
        while (!in_ready);
        advance_layout(it);
        items_taken++;
    endtask

    task automatic send_metric(input logic [7:0] idx, input logic [15:0] l,
                               input logic [15:0] r);
        layout_item_t it;
        it       = make_item(MODE_METRIC);
        it.index = idx;
        it.left  = l;
        it.right = r;
        send_item(it);
    endtask

    task automatic send_colour(input logic [7:0] idx, input logic [31:0] w);
        layout_item_t it;
        it        = make_item(MODE_COLOR);
        it.index  = idx;
        it.colour = w;
        send_item(it);
    endtask

    task automatic send_begin(input logic signed [19:0] x, input logic signed [19:0] y,
                              input logic c);
        layout_item_t it;
        it        = make_item(MODE_BEGIN);
        it.x      = x;
        it.y      = y;
        it.centre = c;
        send_item(it);
    endtask

    task automatic send_glyph(input logic [2:0] m, input logic [7:0] c);
        layout_item_t it;
        it       = make_item(m);
        it.glyph = c;
        send_item(it);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (quad_beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // unused upper data bits carry junk on purpose
    task automatic apply_settings(input logic [11:0] fs, input logic [15:0] spacing,
                                  input logic [15:0] padding, input logic mono,
                                  input logic [1:0] fold, input logic [4:0] plen);
        logic [15:0] junk;
        settle();
        junk = $urandom;
        write_reg(CFG_FONT_SIZE, {junk[15:12], fs});
        write_reg(CFG_CHAR_SPACING, spacing);
        write_reg(CFG_CHAR_PADDING, padding);
        write_reg(CFG_MONOSPACED, {junk[14:0], mono});
        write_reg(CFG_CASE_MODE, {junk[13:0], fold});
        write_reg(CFG_PATTERN_LENGTH, {junk[10:0], plen});
    endtask

    // mostly measure, centred begin, draw; the rest stray commands
    task automatic run_strings(input int budget);
        int sent;
        int n;
        logic [7:0] text [8];
        sent = 0;
        while (sent < budget)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7)
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                begin
                    text[k] = pick_char();
                    send_glyph(MODE_MEASURE, text[k]);
                end
                send_begin(rand_pos(), rand_pos(), $urandom_range(0, 9) != 0);
                for (int k = 0; k < n; k++)
                    send_glyph(MODE_DRAW, text[k]);
                sent += 2 * n + 1;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: send_metric($urandom, rand_frac(), rand_frac());
                    1: send_colour($urandom_range(0, 31), $urandom);
                    2:
                    begin
                        send_glyph($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST),
                                   $urandom);
                        sent--;
                    end
                    3: send_begin(rand_pos(), rand_pos(), $urandom_range(0, 1));
                    4: send_glyph(MODE_MEASURE, pick_char());
                    default: send_glyph(MODE_DRAW, pick_char());
                endcase
                sent++;
            end
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        send_metric(CHAR_SPACE, 16'h0000, 16'hFFFF);
        send_metric("A", 16'hFFFF, 16'h0000);
        send_metric("a", 16'd6554, 16'd9830);
        send_metric(8'h00, 16'h0000, 16'h0000);
        send_metric(8'hFF, 16'hFFFF, 16'hFFFF);
        send_metric("z", rand_frac(), rand_frac());
        send_colour(8'd0, 32'h0000_0000);
        send_colour(8'd15, 32'hFFFF_FFFF);
        // colour slots out of range are dropped
        send_colour(8'd16, $urandom);
        send_colour(8'd255, $urandom);
        send_glyph(MODE_SPARE_FIRST, $urandom);
        send_glyph(MODE_SPARE_LAST, $urandom);
        // saturation at the top corner
        send_begin(POS_MAX, POS_MAX, 1'b0);
        send_glyph(MODE_DRAW, "A");
        send_glyph(MODE_MEASURE, CHAR_SPACE);
        send_glyph(MODE_MEASURE, "A");
        send_glyph(MODE_MEASURE, 8'hFF);
        send_begin(POS_MIN, POS_MIN, 1'b1);
        send_glyph(MODE_DRAW, 8'h00);
        send_glyph(MODE_DRAW, 8'hFF);
        send_glyph(MODE_DRAW, "a");
        send_glyph(MODE_MEASURE, "z");
        send_begin(20'sd100, -20'sd100, 1'b1);
        send_glyph(MODE_DRAW, "z");
        send_glyph(MODE_DRAW, CHAR_SPACE);
    endtask

    task automatic test_table_loads();
        no_gaps = $urandom_range(0, 1);
        for (int k = 0; k < PATTERN_ENTRIES; k++)
            send_colour(k, $urandom);
        no_gaps = 1'b0;
        repeat (40) send_metric($urandom, rand_frac(), rand_frac());
        repeat (8) send_colour($urandom_range(PATTERN_ENTRIES, 255), $urandom);
    endtask

    task automatic test_proportional_strings();
        apply_settings(FONT_SIZE_RESET, $urandom, CHAR_PADDING_RESET, 1'b0,
                       CASE_LOWER, 5'd16);
        run_strings(60);
        // oversized pattern length is clamped
        apply_settings(12'd0, 16'h0000, 16'h0000, 1'b0, CASE_NONE, 5'd31);
        run_strings(40);
        apply_settings(12'hFFF, 16'hFFFF, 16'hFFFF, 1'b0, CASE_UPPER, 5'd7);
        run_strings(40);
    endtask

    task automatic test_monospaced_strings();
        apply_settings(12'hFFF, 16'hFFFF, 16'hFFFF, 1'b1, CASE_UPPER, 5'd3);
        run_strings(50);
        apply_settings(12'd160, $urandom, $urandom, 1'b1, CASE_LOWER, 5'd0);
        run_strings(40);
    endtask

    // shrinking the pattern mid-string leaves the colour slot past the end
    task automatic test_pattern_restart();
        apply_settings($urandom_range(16, 1024), CHAR_SPACING_RESET, $urandom, 1'b0,
                       CASE_NONE, 5'd16);
        repeat (5) send_glyph(MODE_DRAW, pick_char());
        settle();
        write_reg(CFG_PATTERN_LENGTH, 16'd3);
        write_reg(CFG_SPARE_FIRST, $urandom);
        write_reg(CFG_SPARE_LAST, $urandom);
        repeat (4) send_glyph(MODE_DRAW, pick_char());
        settle();
        write_reg(CFG_PATTERN_LENGTH, 16'd1);
        run_strings(30);
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        quad_beat_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (quad_beats_due.size() == 0)
            begin
                $error("beat with nothing outstanding: vert_x %0d, text_width %0d",
                       vert_x, text_width);
                mismatches++;
            end
            else
            begin
                due = quad_beats_due.pop_front();
                check_field("vert_x", due.vx, vert_x);
                check_field("vert_y", due.vy, vert_y);
                check_field("tex_s", due.s, tex_s);
                check_field("tex_t", due.t, tex_t);
                check_field("vertex_color", due.tint, vertex_color);
                check_field("text_width", due.width, text_width);
                check_field("last", due.last_beat, last);
                if (due.last_beat && due.width == 0 && due.s == 0 && due.t == 0)
                    width_beats += 0;
                if (due.tint == 0 && due.s == 0 && due.t == 0)
                    width_beats++;
                else
                    vertex_beats++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int unsigned hold;
        hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
                hold = idle_len();
            if (hold == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                hold--;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        mode         = '0;
        index        = '0;
        left_margin  = '0;
        right_margin = '0;
        color_word   = '0;
        pos_x        = '0;
        pos_y        = '0;
        center       = 1'b0;
        character    = '0;
        no_gaps      = 1'b0;
        mismatches   = 0;
        items_taken  = 0;
        vertex_beats = 0;
        width_beats  = 0;
        cfg_writes   = 0;
        quiet_cycles = 0;
        reset_layout_state();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_table_loads();
        test_proportional_strings();
        test_monospaced_strings();
        test_pattern_restart();
        settle();

        $display("layout run: %0d items in, %0d vertex beats and %0d width beats checked",
                 items_taken, vertex_beats, width_beats);
        $display("%0d register writes over proportional, monospaced, case and pattern setups",
                 cfg_writes);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### proportional_text_quad_layout.f
src/ptql_pkg.sv
src/ptql_front.sv
src/ptql_queue.sv
src/ptql_back.sv
src/proportional_text_quad_layout.sv
src/ptql_checker.sv
verif/proportional_text_quad_layout_test.sv
